@@ hdl/qphi_pkg.sv @@
// shared codes for the quadratic-probe hash insert block
// no dependencies; used by the top level
package qphi_pkg;

    typedef logic [1:0] status_t;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_RANGE = 2'd2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

endpackage

@@ hdl/qphi_ram.sv @@
// simple dual-port table memory, one write and one registered read per cycle
// no dependencies
module qphi_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 31
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/qphi_mod.sv @@
// shared remainder unit, restoring division one dividend bit per cycle
// no dependencies
module qphi_mod #(
    parameter int DW = 31,
    parameter int NW = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [NW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] remainder
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [NW-1:0] rem_reg, rem_next;
    logic [NW-1:0] div_reg, div_next;
    logic [NW:0]   trial;

    assign trial = {rem_reg, quo_reg[DW-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = NW'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = NW'(trial);
            end
            quo_next = quo_reg << 1;
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

@@ hdl/quadratic_probe_hash_insert_top.sv @@
// top level: sequencer, two table banks and the shared remainder unit
// depends on qphi_pkg, qphi_ram, qphi_mod

// Open-addressed hash table with quadratic probing, one item at a time; s_tready is high only
// while the sequencer is idle. After reset a clearing pass over the initial slots runs before
// the first transfer is taken. A read requests the slot, takes the memory data and then outputs
// the result. An insert computes v mod size in the shared remainder unit, then probes with one
// memory read per probe. A stalled result transfer holds the sequencer until the output is free.
// When the table grows, each candidate size is tested by trial divisors in the shared remainder
// unit, the spare bank is cleared at one new slot per cycle, and each occupied old slot is
// rehashed through the remainder unit and probed into the spare bank; the banks then swap roles.
module quadratic_probe_hash_insert_top #(
    parameter int MAX_SLOTS     = 2048,
    parameter int VALUE_BITS    = 31,
    parameter int INITIAL_SLOTS = 11,
    localparam int IDX_W   = $clog2(MAX_SLOTS),
    localparam int SZ_W    = IDX_W + 1,
    localparam int IN_W    = VALUE_BITS + IDX_W,
    localparam int IN_PAD  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W   = IDX_W + VALUE_BITS + 2 * SZ_W,
    localparam int OUT_PAD = ((OUT_W + 7) / 8) * 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [IN_PAD-1:0]  s_tdata,   // value, slot
    input  logic               s_tuser,   // opcode
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_PAD-1:0] m_tdata,   // slot_index, slot_value, table_size, entry_count
    output logic [1:0]         m_tuser    // status
);

    localparam int DW        = (VALUE_BITS > SZ_W) ? VALUE_BITS : SZ_W;
    localparam int INIT_SIZE = (INITIAL_SLOTS > MAX_SLOTS) ? MAX_SLOTS : INITIAL_SLOTS;

    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_RD_REQ  = 4'd2;
    localparam logic [3:0] S_RD_DATA = 4'd3;
    localparam logic [3:0] S_GROW    = 4'd4;
    localparam logic [3:0] S_PT      = 4'd5;
    localparam logic [3:0] S_PT_W    = 4'd6;
    localparam logic [3:0] S_CLR     = 4'd7;
    localparam logic [3:0] S_RH_REQ  = 4'd8;
    localparam logic [3:0] S_RH_CHK  = 4'd9;
    localparam logic [3:0] S_INS     = 4'd10;
    localparam logic [3:0] S_MOD_W   = 4'd11;
    localparam logic [3:0] S_PR_REQ  = 4'd12;
    localparam logic [3:0] S_PR_CHK  = 4'd13;
    localparam logic [3:0] S_OUT     = 4'd14;

    logic [3:0]            state_reg, state_next;
    logic                  cur_reg, cur_next;
    logic                  rh_reg, rh_next;
    logic [SZ_W-1:0]       size_reg, size_next;
    logic [SZ_W-1:0]       count_reg, count_next;
    logic [SZ_W:0]         n_reg, n_next;
    logic [SZ_W-1:0]       d_reg, d_next;
    logic [SZ_W:0]         sq_reg, sq_next;
    logic [SZ_W-1:0]       clr_reg, clr_next;
    logic [SZ_W-1:0]       i_reg, i_next;
    logic [SZ_W-1:0]       pn_reg, pn_next;
    logic [IDX_W-1:0]      pos_reg, pos_next;
    logic [SZ_W-1:0]       dstep_reg, dstep_next;
    logic [SZ_W-1:0]       j_reg, j_next;
    logic [VALUE_BITS-1:0] ins_val_reg, ins_val_next;
    logic [VALUE_BITS-1:0] pv_reg, pv_next;
    logic [IDX_W-1:0]      slot_reg, slot_next;
    qphi_pkg::status_t     res_st_reg, res_st_next;
    logic [IDX_W-1:0]      res_idx_reg, res_idx_next;
    logic [VALUE_BITS-1:0] res_val_reg, res_val_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_PAD-1:0]    m_tdata_reg, m_tdata_next;
    qphi_pkg::status_t     m_tuser_reg, m_tuser_next;
    logic                  rd_bank_reg;

    logic                  wr_en, wr_bank, rd_bank;
    logic [IDX_W-1:0]      wr_addr, rd_addr;
    logic [VALUE_BITS-1:0] wr_data, rdata, rdata0, rdata1;
    logic                  mod_start, mod_done;
    logic [DW-1:0]         mod_dividend;
    logic [SZ_W-1:0]       mod_divisor, mod_rem;
    logic [SZ_W:0]         psum, dsum;
    logic                  probe_bank;

    qphi_ram #(.DEPTH(MAX_SLOTS), .WIDTH(VALUE_BITS)) u_bank0 (
        .clk   (clk),
        .we    (wr_en && !wr_bank),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rdata0)
    );

    qphi_ram #(.DEPTH(MAX_SLOTS), .WIDTH(VALUE_BITS)) u_bank1 (
        .clk   (clk),
        .we    (wr_en && wr_bank),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rdata1)
    );

    qphi_mod #(.DW(DW), .NW(SZ_W)) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dividend),
        .divisor   (mod_divisor),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign rdata      = rd_bank_reg ? rdata1 : rdata0;
    assign probe_bank = rh_reg ? !cur_reg : cur_reg;
    assign psum       = (SZ_W+1)'(pos_reg) + (SZ_W+1)'(dstep_reg);
    assign dsum       = (SZ_W+1)'(dstep_reg) + (SZ_W+1)'(2);

    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        rh_next       = rh_reg;
        size_next     = size_reg;
        count_next    = count_reg;
        n_next        = n_reg;
        d_next        = d_reg;
        sq_next       = sq_reg;
        clr_next      = clr_reg;
        i_next        = i_reg;
        pn_next       = pn_reg;
        pos_next      = pos_reg;
        dstep_next    = dstep_reg;
        j_next        = j_reg;
        ins_val_next  = ins_val_reg;
        pv_next       = pv_reg;
        slot_next     = slot_reg;
        res_st_next   = res_st_reg;
        res_idx_next  = res_idx_reg;
        res_val_next  = res_val_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        wr_en         = 1'b0;
        wr_bank       = cur_reg;
        wr_addr       = '0;
        wr_data       = '0;
        rd_bank       = cur_reg;
        rd_addr       = '0;
        mod_start     = 1'b0;
        mod_dividend  = DW'(ins_val_reg);
        mod_divisor   = size_reg;

        case (state_reg)
            S_INIT:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg[IDX_W-1:0];
                if (clr_reg + SZ_W'(1) == SZ_W'(INIT_SIZE))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + SZ_W'(1);
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    ins_val_next = s_tdata[VALUE_BITS-1:0];
                    slot_next    = s_tdata[IN_W-1:VALUE_BITS];
                    if (s_tuser == qphi_pkg::OP_READ)
                    begin
                        if (SZ_W'(s_tdata[IN_W-1:VALUE_BITS]) >= size_reg)
                        begin
                            res_st_next  = qphi_pkg::ST_RANGE;
                            res_idx_next = s_tdata[IN_W-1:VALUE_BITS];
                            res_val_next = '0;
                            state_next   = S_OUT;
                        end
                        else
                        begin
                            state_next = S_RD_REQ;
                        end
                    end
                    else if ({count_reg, 1'b0} >= {1'b0, size_reg})
                    begin
                        n_next     = {size_reg, 1'b0};
                        state_next = S_GROW;
                    end
                    else
                    begin
                        state_next = S_INS;
                    end
                end
            end
            S_RD_REQ:
            begin
                rd_addr    = slot_reg;
                state_next = S_RD_DATA;
            end
            S_RD_DATA:
            begin
                res_st_next  = qphi_pkg::ST_OK;
                res_idx_next = slot_reg;
                res_val_next = rdata;
                state_next   = S_OUT;
            end
            S_GROW:
            begin
                if (n_reg > (SZ_W+1)'(MAX_SLOTS))
                begin
                    res_st_next  = qphi_pkg::ST_FULL;
                    res_idx_next = '0;
                    res_val_next = '0;
                    state_next   = S_OUT;
                end
                else
                begin
                    d_next     = SZ_W'(2);
                    sq_next    = (SZ_W+1)'(4);
                    state_next = S_PT;
                end
            end
            S_PT:
            begin
                mod_dividend = DW'(n_reg[SZ_W-1:0]);
                mod_divisor  = d_reg;
                if (sq_reg > n_reg)
                begin
                    clr_next   = '0;
                    state_next = S_CLR;
                end
                else
                begin
                    mod_start  = 1'b1;
                    state_next = S_PT_W;
                end
            end
            S_PT_W:
            begin
                if (mod_done)
                begin
                    if (mod_rem == '0)
                    begin
                        n_next     = n_reg + (SZ_W+1)'(1);
                        state_next = S_GROW;
                    end
                    else
                    begin
                        // (d+1)^2 = d^2 + 2d + 1
                        sq_next    = sq_reg + {d_reg, 1'b1};
                        d_next     = d_reg + SZ_W'(1);
                        state_next = S_PT;
                    end
                end
            end
            S_CLR:
            begin
                wr_en   = 1'b1;
                wr_bank = !cur_reg;
                wr_addr = clr_reg[IDX_W-1:0];
                if ((SZ_W+1)'(clr_reg) + (SZ_W+1)'(1) == n_reg)
                begin
                    i_next     = '0;
                    state_next = S_RH_REQ;
                end
                else
                begin
                    clr_next = clr_reg + SZ_W'(1);
                end
            end
            S_RH_REQ:
            begin
                rd_addr = i_reg[IDX_W-1:0];
                if (i_reg == size_reg)
                begin
                    cur_next   = !cur_reg;
                    size_next  = n_reg[SZ_W-1:0];
                    state_next = S_INS;
                end
                else
                begin
                    state_next = S_RH_CHK;
                end
            end
            S_RH_CHK:
            begin
                mod_dividend = DW'(rdata);
                mod_divisor  = n_reg[SZ_W-1:0];
                if (rdata == '0)
                begin
                    i_next     = i_reg + SZ_W'(1);
                    state_next = S_RH_REQ;
                end
                else
                begin
                    mod_start  = 1'b1;
                    rh_next    = 1'b1;
                    pv_next    = rdata;
                    pn_next    = n_reg[SZ_W-1:0];
                    state_next = S_MOD_W;
                end
            end
            S_INS:
            begin
                mod_start  = 1'b1;
                rh_next    = 1'b0;
                pv_next    = ins_val_reg;
                pn_next    = size_reg;
                state_next = S_MOD_W;
            end
            S_MOD_W:
            begin
                if (mod_done)
                begin
                    pos_next   = mod_rem[IDX_W-1:0];
                    dstep_next = SZ_W'(1);
                    j_next     = '0;
                    state_next = S_PR_REQ;
                end
            end
            S_PR_REQ:
            begin
                rd_bank    = probe_bank;
                rd_addr    = pos_reg;
                state_next = S_PR_CHK;
            end
            S_PR_CHK:
            begin
                if (rdata == '0)
                begin
                    wr_en   = 1'b1;
                    wr_bank = probe_bank;
                    wr_addr = pos_reg;
                    wr_data = pv_reg;
                    if (rh_reg)
                    begin
                        i_next     = i_reg + SZ_W'(1);
                        state_next = S_RH_REQ;
                    end
                    else
                    begin
                        count_next   = count_reg + SZ_W'(1);
                        res_st_next  = qphi_pkg::ST_OK;
                        res_idx_next = pos_reg;
                        res_val_next = pv_reg;
                        state_next   = S_OUT;
                    end
                end
                else if (j_reg + SZ_W'(1) == pn_reg)
                begin
                    // probe path exhausted: a rehashed value is dropped
                    if (rh_reg)
                    begin
                        i_next     = i_reg + SZ_W'(1);
                        state_next = S_RH_REQ;
                    end
                    else
                    begin
                        res_st_next  = qphi_pkg::ST_FULL;
                        res_idx_next = '0;
                        res_val_next = '0;
                        state_next   = S_OUT;
                    end
                end
                else
                begin
                    j_next = j_reg + SZ_W'(1);
                    if (psum >= (SZ_W+1)'(pn_reg))
                    begin
                        pos_next = IDX_W'(psum - (SZ_W+1)'(pn_reg));
                    end
                    else
                    begin
                        pos_next = IDX_W'(psum);
                    end
                    if (dsum >= (SZ_W+1)'(pn_reg))
                    begin
                        dstep_next = SZ_W'(dsum - (SZ_W+1)'(pn_reg));
                    end
                    else
                    begin
                        dstep_next = SZ_W'(dsum);
                    end
                    state_next = S_PR_REQ;
                end
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_st_reg;
                    m_tdata_next  = OUT_PAD'({count_reg, size_reg, res_val_reg, res_idx_reg});
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            cur_reg      <= 1'b0;
            rh_reg       <= 1'b0;
            size_reg     <= SZ_W'(INIT_SIZE);
            count_reg    <= '0;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_reg      <= cur_next;
            rh_reg       <= rh_next;
            size_reg     <= size_next;
            count_reg    <= count_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        d_reg       <= d_next;
        sq_reg      <= sq_next;
        i_reg       <= i_next;
        pn_reg      <= pn_next;
        pos_reg     <= pos_next;
        dstep_reg   <= dstep_next;
        j_reg       <= j_next;
        ins_val_reg <= ins_val_next;
        pv_reg      <= pv_next;
        slot_reg    <= slot_next;
        res_st_reg  <= res_st_next;
        res_idx_reg <= res_idx_next;
        res_val_reg <= res_val_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        rd_bank_reg <= rd_bank;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef ASSERT_OFF
    a_size_cap: assert property (@(posedge clk) disable iff (!rst_n)
        size_reg <= SZ_W'(MAX_SLOTS))
        else $error("table size above capacity");

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        {count_reg, 1'b0} <= ({1'b0, size_reg} + (SZ_W+1)'(1)))
        else $error("entry count beyond load limit");

    a_probe_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PR_REQ) |-> (SZ_W'(pos_reg) < pn_reg))
        else $error("probe position outside table");

    a_mod_done: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == S_PT_W || state_reg == S_MOD_W))
        else $error("remainder finished while not awaited");
`endif

endmodule

@@ bench/tb_quadratic_probe_hash_insert_top.sv @@
// testbench for the quadratic-probe hash insert block: directed and random inserts and reads
// checked against a behavioral table model kept in the bench; depends on qphi_pkg and the top level
module tb_quadratic_probe_hash_insert_top;

    localparam int SLOTS_MAX = 2048;
    localparam int START_SIZE = 11;
    localparam logic [30:0] VAL_TOP = 31'h7fff_ffff;

    typedef struct packed {
        qphi_pkg::status_t status;
        logic [10:0]       idx;
        logic [30:0]       val;
        logic [11:0]       size;
        logic [11:0]       count;
    } table_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // value, slot
    logic        s_tuser;   // opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // slot_index, slot_value, table_size, entry_count
    logic [1:0]  m_tuser;   // status

    // bench copy of the table
    logic [30:0] hash_slots [SLOTS_MAX];
    logic [30:0] spare_slots [SLOTS_MAX];
    int unsigned hash_size;
    int unsigned hash_count;

    table_result_t pending_results[$];
    int          mismatches;
    bit          idle_en;
    int          hold_req;
    int          hold_seen;
    int          hold_left;

    quadratic_probe_hash_insert_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic bit is_prime(int unsigned n);
        int unsigned d;
        if (n <= 1)
            return 0;
        for (d = 2; d * d <= n; d++)
            if (n % d == 0)
                return 0;
        return 1;
    endfunction

    // first empty slot on the quadratic path, -1 if none within n probes
    function automatic int find_empty_slot(bit use_spare, int unsigned n, logic [30:0] v);
        longint unsigned base;
        longint unsigned j;
        int unsigned pos;
        base = v % n;
        for (j = 0; j < n; j++)
        begin
            pos = int'((base + j * j) % n);
            if ((use_spare ? spare_slots[pos] : hash_slots[pos]) == 31'd0)
                return pos;
        end
        return -1;
    endfunction

    function automatic bit grow_hash_table();
        int unsigned n;
        int pos;
        n = hash_size * 2;
        while (n <= SLOTS_MAX && !is_prime(n))
            n++;
        if (n > SLOTS_MAX)
            return 0;
        for (int i = 0; i < SLOTS_MAX; i++)
            spare_slots[i] = '0;
        for (int i = 0; i < hash_size; i++)
        begin
            if (hash_slots[i] != 31'd0)
            begin
                pos = find_empty_slot(1, n, hash_slots[i]);
                if (pos >= 0)
                    spare_slots[pos] = hash_slots[i];
            end
        end
        for (int i = 0; i < SLOTS_MAX; i++)
            hash_slots[i] = spare_slots[i];
        hash_size = n;
        return 1;
    endfunction

    function automatic table_result_t apply_table_op(logic op, logic [30:0] v, logic [10:0] slot);
        table_result_t r;
        bit ok;
        int pos;
        r = '0;
        r.status = qphi_pkg::ST_OK;
        if (op == qphi_pkg::OP_READ)
        begin
            r.idx = slot;
            if (slot >= hash_size)
                r.status = qphi_pkg::ST_RANGE;
            else
                r.val = hash_slots[slot];
        end
        else
        begin
            ok = 1;
            if (hash_count * 2 >= hash_size)
                ok = grow_hash_table();
            if (!ok)
                r.status = qphi_pkg::ST_FULL;
            else
            begin
                pos = find_empty_slot(0, hash_size, v);
                if (pos < 0)
                    r.status = qphi_pkg::ST_FULL;
                else
                begin
                    hash_slots[pos] = v;
                    hash_count++;
                    r.idx = pos[10:0];
                    r.val = v;
                end
            end
        end
        r.size = hash_size[11:0];
        r.count = hash_count[11:0];
        return r;
    endfunction

    task automatic send_op(logic op, logic [30:0] v, logic [10:0] slot);
        @(negedge clk);
        while (idle_en && $urandom_range(99) < 21)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {6'd0, slot, v};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(apply_table_op(op, v, slot));
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // receiver: random stalls plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            m_tready = 1'b0;
            hold_left--;
        end
        else
            m_tready = !idle_en || ($urandom_range(99) >= 21);
    end

    always @(posedge clk)
    begin
        table_result_t want;
        table_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tuser, m_tdata[10:0], m_tdata[41:11], m_tdata[53:42], m_tdata[65:54]};
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result transfer, actual %h", $time, got);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status != want.status)
                    $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                if (got.idx != want.idx)
                    $display("%0t: slot_index expected %0d actual %0d", $time, want.idx, got.idx);
                if (got.val != want.val)
                    $display("%0t: slot_value expected %h actual %h", $time, want.val, got.val);
                if (got.size != want.size)
                    $display("%0t: table_size expected %0d actual %0d", $time, want.size, got.size);
                if (got.count != want.count)
                    $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                             got.count);
                if (got != want)
                    mismatches++;
            end
        end
    end

    task automatic test_empty_reads();
        send_op(qphi_pkg::OP_READ, 31'd0, 11'd0);
        send_op(qphi_pkg::OP_READ, VAL_TOP, 11'd10);
        send_op(qphi_pkg::OP_READ, 31'd0, 11'd11);
        send_op(qphi_pkg::OP_READ, 31'd0, 11'd2047);
    endtask

    task automatic test_insert_extremes();
        send_op(qphi_pkg::OP_INSERT, 31'd0, 11'd0);
        send_op(qphi_pkg::OP_INSERT, VAL_TOP, 11'h7ff);
        send_op(qphi_pkg::OP_INSERT, 31'd1, 11'd0);
        send_op(qphi_pkg::OP_READ, 31'd0, 11'd1);
        send_op(qphi_pkg::OP_READ, 31'd0, 11'd0);
    endtask

    // same remainder mod 11 and 23 to force several probes and growth
    task automatic test_collisions();
        for (int i = 1; i <= 8; i++)
            send_op(qphi_pkg::OP_INSERT, 31'(i * 253), 11'd0);
        for (int i = 0; i < 4; i++)
            send_op(qphi_pkg::OP_READ, 31'd0, 11'(i));
    endtask

    task automatic test_backpressure();
        hold_req++;
        for (int i = 0; i < 6; i++)
            send_op(qphi_pkg::OP_INSERT, 31'($urandom_range(500, 1)), 11'($urandom));
        wait_for_drain();
    endtask

    task automatic test_random_mix(int n_items);
        logic op;
        logic [30:0] v;
        logic [10:0] slot;
        for (int i = 0; i < n_items; i++)
        begin
            idle_en = !(i >= 300 && i < 450);
            if (i == 900)
                wait_for_drain();
            op = ($urandom_range(99) < 35) ? qphi_pkg::OP_READ : qphi_pkg::OP_INSERT;
            case ($urandom_range(9))
                0:       v = 31'd0;
                1, 2:    v = 31'($urandom_range(4 * hash_size, 1));
                3:       v = 31'(hash_size * $urandom_range(20, 1));
                default: v = 31'($urandom);
            endcase
            if ($urandom_range(9) == 0)
                slot = 11'($urandom);
            else
                slot = 11'($urandom_range(hash_size - 1));
            send_op(op, v, slot);
        end
        idle_en = 1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = qphi_pkg::OP_INSERT;
        s_tdata = '0;
        m_tready = 1'b0;
        mismatches = 0;
        idle_en = 1;
        hold_req = 0;
        hold_seen = 0;
        hold_left = 0;
        for (int i = 0; i < SLOTS_MAX; i++)
        begin
            hash_slots[i] = '0;
            spare_slots[i] = '0;
        end
        hash_size = START_SIZE;
        hash_count = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_reads();
        test_insert_extremes();
        test_collisions();
        test_backpressure();
        test_random_mix(1780);

        wait_for_drain();
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/qphi_pkg.sv
hdl/qphi_ram.sv
hdl/qphi_mod.sv
hdl/quadratic_probe_hash_insert_top.sv
bench/tb_quadratic_probe_hash_insert_top.sv
